FILE: src/asu_pkg.sv
// ----------------------------------------------------------------------------
// asu_pkg
// Shared types and constants for the Annex B access unit splitter.
// ----------------------------------------------------------------------------
package asu_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int OUT_W           = 24;
    localparam int TYPE_W          = 6;
    localparam int TOKEN_DEPTH     = 4;
    localparam int RESULT_DEPTH    = 4;

    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_ONE     = 8'h01;
    localparam logic [7:0] H264_TYPE_M  = 8'h1F;
    localparam logic [7:0] H265_TYPE_M  = 8'h7E;

    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_H265 = 1'b1;

    localparam logic [TYPE_W-1:0] H264_SLICE   = 6'd1;
    localparam logic [TYPE_W-1:0] H264_IDR     = 6'd5;
    localparam logic [TYPE_W-1:0] H265_TRAIL_N = 6'd0;
    localparam logic [TYPE_W-1:0] H265_TRAIL_R = 6'd1;
    localparam logic [TYPE_W-1:0] H265_RASL_N  = 6'd8;
    localparam logic [TYPE_W-1:0] H265_RASL_R  = 6'd9;
    localparam logic [TYPE_W-1:0] H265_IDR     = 6'd19;
    localparam logic [TYPE_W-1:0] H265_CRA     = 6'd21;

    localparam logic REG_CODEC_MODE = 1'b0;

    // classified byte handed from front to back
    typedef struct packed {
        logic              start;
        logic              code4;
        logic              hdr;
        logic              hdr_pic;
        logic              hdr_key;
        logic [TYPE_W-1:0] hdr_type;
        logic              last;
    } asu_token_t;

    typedef struct packed {
        logic [OUT_W-1:0]  offset;
        logic [OUT_W-1:0]  length;
        logic              key;
        logic [TYPE_W-1:0] pic_type;
    } asu_result_t;

endpackage

FILE: src/asu_fifo.sv
// ----------------------------------------------------------------------------
// asu_fifo
// Small register FIFO with count-based full/empty flags.
// ----------------------------------------------------------------------------
module asu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/asu_front.sv
// ----------------------------------------------------------------------------
// asu_front
// Start code detection and NAL header classification, one byte per cycle in which fire is high.
// ----------------------------------------------------------------------------
module asu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                codec_mode,
    input  logic                fire,
    input  logic [7:0]          data_byte,
    input  logic                end_of_stream,
    output asu_pkg::asu_token_t token
);
    import asu_pkg::*;

    logic [1:0]        zero_run_reg, zero_run_next;
    logic              await_reg, await_next;
    logic              is_zero, is_sc;
    logic [TYPE_W-1:0] t264, t265;
    logic              pic264, key264, pic265, key265;

    assign is_zero = (data_byte == BYTE_ZERO);
    assign is_sc   = (data_byte == BYTE_ONE) && zero_run_reg[1];

    always_comb
    begin
        t264   = TYPE_W'(data_byte & H264_TYPE_M);
        t265   = TYPE_W'((data_byte & H265_TYPE_M) >> 1);
        key264 = (t264 == H264_IDR);
        pic264 = key264 || (t264 == H264_SLICE);
        key265 = (t265 == H265_IDR) || (t265 == H265_CRA);
        pic265 = key265 || (t265 == H265_TRAIL_N) || (t265 == H265_TRAIL_R)
              || (t265 == H265_RASL_N) || (t265 == H265_RASL_R);
    end

    always_comb
    begin
        token.start = is_sc;
        token.code4 = (zero_run_reg == 2'd3);
        token.hdr   = await_reg;
        token.last  = end_of_stream;
        unique case (codec_mode)
            CODEC_H264:
            begin
                token.hdr_pic  = pic264;
                token.hdr_key  = key264;
                token.hdr_type = t264;
            end
            CODEC_H265:
            begin
                token.hdr_pic  = pic265;
                token.hdr_key  = key265;
                token.hdr_type = t265;
            end
            default:
            begin
                token.hdr_pic  = 1'b0;
                token.hdr_key  = 1'b0;
                token.hdr_type = '0;
            end
        endcase
    end

    always_comb
    begin
        if (end_of_stream)
        begin
            zero_run_next = '0;
        end
        else if (is_zero)
        begin
            zero_run_next = (zero_run_reg == 2'd3) ? 2'd2 : zero_run_reg + 2'd1;
        end
        else
        begin
            zero_run_next = '0;
        end
        await_next = is_sc && !end_of_stream;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg <= '0;
            await_reg    <= 1'b0;
        end
        else if (fire)
        begin
            zero_run_reg <= zero_run_next;
            await_reg    <= await_next;
        end
    end

endmodule

FILE: src/asu_back.sv
// ----------------------------------------------------------------------------
// asu_back
// Frame accounting: byte position, frame length and frame emission.
// ----------------------------------------------------------------------------
module asu_back #(
    parameter int LENGTH_BITS = asu_pkg::LENGTH_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  asu_pkg::asu_token_t  token,
    output logic                 emit,
    output asu_pkg::asu_result_t result
);
    import asu_pkg::*;

    localparam int L = LENGTH_BITS;
    localparam logic [L-1:0] LEN_MAX = {L{1'b1}};

    logic              synced_reg, synced_next;
    logic              pic_reg, pic_next;
    logic              key_reg, key_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic [L-1:0]      start_reg, start_next;
    logic [L-1:0]      count_reg, count_next;
    logic [L-1:0]      pos_reg, pos_next;

    logic              cur_pic, cur_key;
    logic [TYPE_W-1:0] cur_type;
    logic [L-1:0]      count_inc, code_len, len, out_start;
    logic [L+OUT_W-1:0] start_ext, len_ext;

    always_comb
    begin
        count_inc = (synced_reg && (count_reg != LEN_MAX)) ? count_reg + 1'b1 : count_reg;
        cur_pic   = token.hdr ? token.hdr_pic  : pic_reg;
        cur_key   = token.hdr ? token.hdr_key  : key_reg;
        cur_type  = token.hdr ? token.hdr_type : type_reg;
        code_len  = token.code4 ? L'(4) : L'(3);

        synced_next = synced_reg;
        pic_next    = cur_pic;
        key_next    = cur_key;
        type_next   = cur_type;
        start_next  = start_reg;
        count_next  = count_inc;
        pos_next    = pos_reg + 1'b1;
        emit        = 1'b0;
        len         = count_inc;
        out_start   = start_reg;

        if (token.start)
        begin
            if (synced_reg && cur_pic)
            begin
                emit = 1'b1;
                len  = (count_inc == LEN_MAX) ? LEN_MAX : count_inc - code_len;
            end
            if (!synced_reg || cur_pic)
            begin
                start_next = token.code4 ? pos_reg - L'(3) : pos_reg - L'(2);
                count_next = code_len;
            end
            synced_next = 1'b1;
            pic_next    = 1'b0;
            key_next    = 1'b0;
            type_next   = '0;
        end

        if (token.last)
        begin
            if (!emit && synced_next && pic_next)
            begin
                emit = 1'b1;
                len  = count_next;
            end
            synced_next = 1'b0;
            pic_next    = 1'b0;
            key_next    = 1'b0;
            type_next   = '0;
            start_next  = '0;
            count_next  = '0;
            pos_next    = '0;
        end

        start_ext       = {{OUT_W{1'b0}}, out_start};
        len_ext         = {{OUT_W{1'b0}}, len};
        result.offset   = start_ext[OUT_W-1:0];
        result.length   = len_ext[OUT_W-1:0];
        result.key      = cur_key;
        result.pic_type = cur_type;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg <= 1'b0;
            pic_reg    <= 1'b0;
            key_reg    <= 1'b0;
            type_reg   <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end
        else if (fire)
        begin
            synced_reg <= synced_next;
            pic_reg    <= pic_next;
            key_reg    <= key_next;
            type_reg   <= type_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

FILE: src/annexb_access_unit_splitter_top.sv
// A frame request passes through the token queue and then the result queue before it
// is visible (empty low). Throughput: one byte per cycle while full stays low; a
// 4-entry byte queue and a 4-entry result queue absorb stalls. Reset clears all parse
// state, both queues and codec_mode (H.264). An end-of-stream byte returns parse state to reset.
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter_top
// Annex B byte stream splitter: emits offset, length and type of each frame.
// ----------------------------------------------------------------------------
module annexb_access_unit_splitter_top #(
    parameter int LENGTH_BITS = asu_pkg::LENGTH_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // byte input
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_stream,
    // frame output
    input  logic                         pop,
    output logic                         empty,
    output logic [asu_pkg::OUT_W-1:0]    frame_offset,
    output logic [asu_pkg::OUT_W-1:0]    frame_length,
    output logic                         key_frame,
    output logic [asu_pkg::TYPE_W-1:0]   picture_type,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import asu_pkg::*;

    logic        codec_mode_reg, codec_mode_next;
    logic        in_fire, tok_empty, tok_full, back_fire, res_full, emit;
    asu_token_t  tok_in, tok_out;
    asu_result_t res_in, res_out;

    assign pready = 1'b1;

    always_comb
    begin
        codec_mode_next = codec_mode_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_CODEC_MODE))
        begin
            codec_mode_next = pwdata[0];
        end
        prdata = '0;
        if (paddr[2] == REG_CODEC_MODE)
        begin
            prdata = {31'b0, codec_mode_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg <= CODEC_H264;
        end
        else
        begin
            codec_mode_reg <= codec_mode_next;
        end
    end

    assign in_fire   = push && !tok_full;
    assign full      = tok_full;
    assign back_fire = !tok_empty && !res_full;

    asu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .codec_mode    (codec_mode_reg),
        .fire          (in_fire),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .token         (tok_in)
    );

    asu_fifo #(
        .WIDTH ($bits(asu_token_t)),
        .DEPTH (TOKEN_DEPTH)
    ) u_tok_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_fire),
        .wr_data (tok_in),
        .rd_en   (back_fire),
        .rd_data (tok_out),
        .full    (tok_full),
        .empty   (tok_empty)
    );

    asu_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (back_fire),
        .token  (tok_out),
        .emit   (emit),
        .result (res_in)
    );

    asu_fifo #(
        .WIDTH ($bits(asu_result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_fire && emit),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    assign frame_offset = res_out.offset;
    assign frame_length = res_out.length;
    assign key_frame    = res_out.key;
    assign picture_type = res_out.pic_type;

endmodule

FILE: tb/sv/frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_checker
// Watches the byte, frame and register ports of the Annex B splitter, parses
// every accepted byte request with its own start code and NAL header logic,
// and compares each popped frame request field by field with the oldest
// predicted frame. Register writes and reads are tracked on the APB port.
// ----------------------------------------------------------------------------
module frame_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         full,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_stream,
    input  logic                         pop,
    input  logic                         empty,
    input  logic [asu_pkg::OUT_W-1:0]    frame_offset,
    input  logic [asu_pkg::OUT_W-1:0]    frame_length,
    input  logic                         key_frame,
    input  logic [asu_pkg::TYPE_W-1:0]   picture_type,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    output int                           mismatches,
    output int                           outstanding
);
    import asu_pkg::*;

    localparam logic [2:0]       CODEC_MODE_ADDR = 3'(4 * int'(REG_CODEC_MODE));
    localparam logic [OUT_W-1:0] COUNT_MAX       = '1;
    localparam int               REPORT_MAX      = 100;

    logic              codec;
    logic [1:0]        zero_run;
    logic              synced;
    logic              await_hdr;
    logic              nal_pic;
    logic              nal_key;
    logic [TYPE_W-1:0] nal_type;
    logic [OUT_W-1:0]  frame_start;
    logic [OUT_W-1:0]  frame_count;
    logic [OUT_W-1:0]  stream_pos;
    asu_result_t       frames_due[$];

    task automatic note_mismatch(input string what, input longint want, input longint got);
        if (mismatches < REPORT_MAX)
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    task automatic clear_parse();
        zero_run    = '0;
        synced      = 1'b0;
        await_hdr   = 1'b0;
        nal_pic     = 1'b0;
        nal_key     = 1'b0;
        nal_type    = '0;
        frame_start = '0;
        frame_count = '0;
        stream_pos  = '0;
    endtask

    task automatic classify(input logic [7:0] hdr);
        logic [TYPE_W-1:0] t;
        if (codec == CODEC_H264)
        begin
            t       = TYPE_W'(hdr & H264_TYPE_M);
            nal_key = (t == H264_IDR);
            nal_pic = (t == H264_SLICE) || (t == H264_IDR);
        end
        else
        begin
            t       = TYPE_W'((hdr & H265_TYPE_M) >> 1);
            nal_key = (t == H265_IDR) || (t == H265_CRA);
            nal_pic = nal_key || (t == H265_TRAIL_N) || (t == H265_TRAIL_R)
                      || (t == H265_RASL_N) || (t == H265_RASL_R);
        end
        nal_type = t;
    endtask

    task automatic record_frame(input logic [OUT_W-1:0] len);
        asu_result_t frame;
        frame.offset   = frame_start;
        frame.length   = len;
        frame.key      = nal_key;
        frame.pic_type = nal_type;
        frames_due.push_back(frame);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [2:0] code_len;
        logic       emitted;
        emitted = 1'b0;
        if (synced && frame_count != COUNT_MAX)
            frame_count++;
        if (await_hdr)
        begin
            classify(b);
            await_hdr = 1'b0;
        end
        if (b == BYTE_ZERO)
        begin
            zero_run = (zero_run < 2'd3) ? zero_run + 2'd1 : 2'd2;
        end
        else if (b == BYTE_ONE && zero_run >= 2'd2)
        begin
            code_len = (zero_run == 2'd3) ? 3'd4 : 3'd3;
            zero_run = '0;
            if (synced && nal_pic)
            begin
                record_frame((frame_count == COUNT_MAX) ? COUNT_MAX : frame_count - code_len);
                emitted = 1'b1;
            end
            if (!synced || nal_pic)
            begin
                frame_start = stream_pos + OUT_W'(1) - OUT_W'(code_len);
                frame_count = OUT_W'(code_len);
            end
            synced    = 1'b1;
            await_hdr = 1'b1;
            nal_pic   = 1'b0;
            nal_key   = 1'b0;
            nal_type  = '0;
        end
        else
        begin
            zero_run = '0;
        end
        stream_pos++;
        if (last)
        begin
            if (!emitted && synced && nal_pic)
                record_frame(frame_count);
            clear_parse();
        end
    endtask

    task automatic check_frame();
        asu_result_t want;
        if (frames_due.size() == 0)
        begin
            if (mismatches < REPORT_MAX)
                $display("%0t: frame request with none expected: offset %0d length %0d",
                         $time, frame_offset, frame_length);
            mismatches++;
        end
        else
        begin
            want = frames_due.pop_front();
            if (frame_offset !== want.offset)
                note_mismatch("frame_offset", want.offset, frame_offset);
            if (frame_length !== want.length)
                note_mismatch("frame_length", want.length, frame_length);
            if (key_frame !== want.key)
                note_mismatch("key_frame", want.key, key_frame);
            if (picture_type !== want.pic_type)
                note_mismatch("picture_type", want.pic_type, picture_type);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec = CODEC_H264;
            clear_parse();
            frames_due.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (pop && !empty)
                check_frame();
            if (push && !full)
                parse_byte(data_byte, end_of_stream);
            if (psel && penable && pready && paddr == CODEC_MODE_ADDR)
            begin
                if (pwrite)
                    codec = pwdata[0];
                else if (prdata !== {31'b0, codec})
                    note_mismatch("prdata", {31'b0, codec}, prdata);
            end
            outstanding = frames_due.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives Annex B byte streams into the access unit splitter in both codec
// modes: a short directed stream per mode, then random streams built from
// well-formed NAL units mixed with noise and early stream ends. Both the
// byte and frame sides idle at random; frame_checker judges the results.
// ----------------------------------------------------------------------------
module testbench;
    import asu_pkg::*;

    localparam int         IDLE_MAX        = 16;
    localparam int         CYCLE_LIMIT     = 200_000;
    localparam int         SETTLE_CYCLES   = 12;
    localparam logic [2:0] CODEC_MODE_ADDR = 3'(4 * int'(REG_CODEC_MODE));
    localparam logic [2:0] SPARE_ADDR      = 3'd4;

    // bit 8 marks the last byte of a stream
    localparam logic [8:0] H264_SCRIPT[28] = '{
        9'h0FF,                                 // dropped, no start code yet
        9'h000, 9'h000, 9'h001, 9'h065, 9'h080, // 3-byte code, IDR
        9'h000, 9'h000, 9'h000, 9'h001, 9'h041, // 4-byte code closes IDR, slice
        9'h000, 9'h000, 9'h000, 9'h000, 9'h001, // even run: trailing zero in slice
        9'h000,                                 // zero header joins next code
        9'h000, 9'h001, 9'h025, 9'h19F,         // IDR ends at end marker
        9'h000, 9'h000, 9'h001, 9'h0E1,
        9'h000, 9'h000, 9'h101                  // end marker on code, no header
    };
    localparam logic [8:0] H265_SCRIPT[13] = '{
        9'h000, 9'h000, 9'h001, 9'h026,         // IDR_W_RADL
        9'h000, 9'h000, 9'h001, 9'h002,         // TRAIL_R
        9'h000, 9'h000, 9'h001, 9'h07E,         // type 63, not a picture
        9'h1FF                                  // unfinished frame dropped
    };

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                push          = 1'b0;
    logic                full;
    logic [7:0]          data_byte     = '0;
    logic                end_of_stream = 1'b0;
    logic                pop           = 1'b0;
    logic                empty;
    logic [OUT_W-1:0]    frame_offset;
    logic [OUT_W-1:0]    frame_length;
    logic                key_frame;
    logic [TYPE_W-1:0]   picture_type;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [2:0]          paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;

    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    int   bytes_sent  = 0;
    bit   steady      = 1'b0;
    logic codec_sel   = CODEC_H264;

    annexb_access_unit_splitter_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .pop           (pop),
        .empty         (empty),
        .frame_offset  (frame_offset),
        .frame_length  (frame_length),
        .key_frame     (key_frame),
        .picture_type  (picture_type),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    frame_checker frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .pop           (pop),
        .empty         (empty),
        .frame_offset  (frame_offset),
        .frame_length  (frame_length),
        .key_frame     (key_frame),
        .picture_type  (picture_type),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int idle_gap();
        return steady ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic logic [7:0] pick_header();
        logic [TYPE_W-1:0] kind;
        if (codec_sel == CODEC_H264)
        begin
            case ($urandom_range(0, 3))
                0:       kind = H264_SLICE;
                1:       kind = H264_IDR;
                default: kind = TYPE_W'($urandom_range(0, 31));
            endcase
            return {3'($urandom), kind[4:0]};
        end
        case ($urandom_range(0, 9))
            0:       kind = H265_TRAIL_N;
            1:       kind = H265_TRAIL_R;
            2:       kind = H265_RASL_N;
            3:       kind = H265_RASL_R;
            4:       kind = H265_IDR;
            5:       kind = H265_CRA;
            default: kind = TYPE_W'($urandom_range(0, 63));
        endcase
        return {1'($urandom), kind, 1'($urandom)};
    endfunction

    // one byte request; called and left at a falling edge with push possibly high
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        data_byte     <= b;
        end_of_stream <= last;
        push          <= 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_nal();
        int zeros;
        zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3);
        repeat (zeros) send_byte(BYTE_ZERO, 1'b0);
        send_byte(BYTE_ONE, $urandom_range(0, 60) == 0);
        send_byte(pick_header(), $urandom_range(0, 40) == 0);
        repeat ($urandom_range(0, 12))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 80) == 0);
    endtask

    task automatic send_random(input int count);
        int target;
        int pick;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                case ($urandom_range(0, 2))
                    0:       send_byte(BYTE_ZERO, $urandom_range(0, 9) == 0);
                    1:       send_byte(BYTE_ONE, $urandom_range(0, 9) == 0);
                    default: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                endcase
            end
            else if (pick == 2)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else
            begin
                send_nal();
            end
        end
    endtask

    // hold the byte side until every predicted frame has been popped
    task automatic settle();
        push <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : frame_drain
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = idle_gap();
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (H264_SCRIPT[i])
            send_byte(H264_SCRIPT[i][7:0], H264_SCRIPT[i][8]);
        send_random(210);

        settle();
        apb_access(1'b1, CODEC_MODE_ADDR, 32'h0000_0001);
        codec_sel = CODEC_H265;
        apb_access(1'b0, CODEC_MODE_ADDR, '0);
        foreach (H265_SCRIPT[i])
            send_byte(H265_SCRIPT[i][7:0], H265_SCRIPT[i][8]);
        send_random(210);

        // write to an unmapped index must leave codec_mode alone
        settle();
        apb_access(1'b1, SPARE_ADDR, 32'h0000_0000);
        apb_access(1'b0, CODEC_MODE_ADDR, '0);
        steady = 1'b1;
        send_random(150);
        steady = 1'b0;

        settle();
        apb_access(1'b1, CODEC_MODE_ADDR, 32'hFFFF_FFFE);
        codec_sel = CODEC_H264;
        apb_access(1'b0, CODEC_MODE_ADDR, '0);
        send_random(105);
        settle();
        send_random(105);

        settle();
        apb_access(1'b1, CODEC_MODE_ADDR, 32'hFFFF_FFFF);
        codec_sel = CODEC_H265;
        send_random(110);
        steady = 1'b1;
        send_random(110);
        steady = 1'b0;

        settle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: annexb_access_unit_splitter_top.f
src/asu_pkg.sv
src/asu_fifo.sv
src/asu_front.sv
src/asu_back.sv
src/annexb_access_unit_splitter_top.sv
tb/sv/frame_checker.sv
tb/sv/testbench.sv
